@@ hdl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types and constants for the lfu cache with lru tie-break
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int KEY_W         = 32;
   localparam int DATA_W        = 32;
   localparam int USE_W         = 32;
   localparam int CAP_W         = 5;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [CAP_W-1:0] CAP_RESET        = CAP_W'(16);
   localparam logic             CSR_IDX_CAPACITY = 1'b0;
   localparam logic             OP_GET           = 1'b0;
   localparam logic             OP_PUT           = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_DONE
   } fsm_state_type;

   typedef enum logic [1:0] {
      AGE_NONE,
      AGE_YOUNGER,
      AGE_ALL
   } age_mode_type;

endpackage

@@ hdl/lfu_cache_lru_tiebreak.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// key-value cache, least-frequently-used replacement, oldest entry on a tie
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_opcode, req_key, req_value          start high and busy low
//  response  rsp_hit, rsp_read_value, rsp_evicted,   rsp_strobe, one cycle,
//            rsp_evicted_key                         cannot be held off
//  csr       psel, penable, pwrite, paddr, pwdata,   apb write, pready high
//            prdata, pready
//
//  an operation that writes back makes two sweeps between the accepting edge and
//  the response beat; a get miss or any put at capacity zero skips the
//  second sweep; start is taken again in the cycle after the beat
//  both sweeps go through the single ram read port, which reads all entries
//  once for match and victim search and once for age update and write-back
//  reset clears the valid bits and the fill count and sets the capacity to 16
//  the response is never stalled; busy stays high until it has gone out
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak import lfu_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic signed [KEY_W-1:0]      req_key,
   input  logic signed [DATA_W-1:0]     req_value,
   output logic                         rsp_strobe,
   output logic                         rsp_hit,
   output logic signed [DATA_W-1:0]     rsp_read_value,
   output logic                         rsp_evicted,
   output logic signed [KEY_W-1:0]      rsp_evicted_key,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW = AW;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > CAP_W) ? CW : CAP_W;
   localparam int WW = KEY_W + DATA_W + USE_W + RW;

   fsm_state_type          state_ff, state_in;
   logic                   op_ff, op_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [DATA_W-1:0]      val_ff, val_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          pidx_ff, pidx_in;

   logic                   found_ff, found_in;
   logic [AW-1:0]          mslot_ff, mslot_in;
   logic [DATA_W-1:0]      mdata_ff, mdata_in;
   logic [USE_W-1:0]       mcount_ff, mcount_in;
   logic [RW-1:0]          mrank_ff, mrank_in;

   logic                   have_ff, have_in;
   logic [AW-1:0]          vslot_ff, vslot_in;
   logic [KEY_W-1:0]       vkey_ff, vkey_in;
   logic [USE_W-1:0]       vcount_ff, vcount_in;
   logic [RW-1:0]          vrank_ff, vrank_in;

   logic                   free_ff, free_in;
   logic [AW-1:0]          fslot_ff, fslot_in;

   logic [AW-1:0]          slot_ff, slot_in;
   logic [RW-1:0]          ref_ff, ref_in;
   age_mode_type           mode_ff, mode_in;
   logic [KEY_W-1:0]       nkey_ff, nkey_in;
   logic [DATA_W-1:0]      ndata_ff, ndata_in;
   logic [USE_W-1:0]       ncount_ff, ncount_in;

   logic [DEPTH-1:0]       valid_ff, valid_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;

   logic                   hit_ff, hit_in;
   logic [DATA_W-1:0]      rdv_ff, rdv_in;
   logic                   ev_ff, ev_in;
   logic [KEY_W-1:0]       evk_ff, evk_in;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [WW-1:0]          ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [WW-1:0]          ram_rd_data;

   logic [KEY_W-1:0]       r_key;
   logic [DATA_W-1:0]      r_data;
   logic [USE_W-1:0]       r_count;
   logic [RW-1:0]          r_rank;
   logic                   p_valid;
   logic                   better;
   logic [MW-1:0]          cap_eff;
   logic                   full;
   logic                   cap_zero;
   logic [USE_W-1:0]       mcount_inc;
   logic                   csr_wr;

   lfu_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign r_key   = ram_rd_data[WW-1 -: KEY_W];
   assign r_data  = ram_rd_data[WW-KEY_W-1 -: DATA_W];
   assign r_count = ram_rd_data[RW+USE_W-1 -: USE_W];
   assign r_rank  = ram_rd_data[RW-1:0];
   assign p_valid = valid_ff[pidx_ff];

   // victim compare unit: smaller use count wins, older rank breaks the tie
   assign better = (r_count < vcount_ff) ||
                   ((r_count == vcount_ff) && (r_rank > vrank_ff));

   assign cap_eff    = (MW'(cap_ff) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(cap_ff);
   assign cap_zero   = (cap_eff == '0);
   assign full       = (MW'(fill_ff) >= cap_eff);
   assign mcount_inc = (mcount_ff == '1) ? mcount_ff : mcount_ff + USE_W'(1);

   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == CSR_IDX_CAPACITY);
   assign cap_in = csr_wr ? pwdata[CAP_W-1:0] : cap_ff;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_CAPACITY) ? CSR_DATA_W'(cap_ff) : '0;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      found_in    = found_ff;
      mslot_in    = mslot_ff;
      mdata_in    = mdata_ff;
      mcount_in   = mcount_ff;
      mrank_in    = mrank_ff;
      have_in     = have_ff;
      vslot_in    = vslot_ff;
      vkey_in     = vkey_ff;
      vcount_in   = vcount_ff;
      vrank_in    = vrank_ff;
      free_in     = free_ff;
      fslot_in    = fslot_ff;
      slot_in     = slot_ff;
      ref_in      = ref_ff;
      mode_in     = mode_ff;
      nkey_in     = nkey_ff;
      ndata_in    = ndata_ff;
      ncount_in   = ncount_ff;
      valid_in    = valid_ff;
      fill_in     = fill_ff;
      hit_in      = hit_ff;
      rdv_in      = rdv_ff;
      ev_in       = ev_ff;
      evk_in      = evk_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cnt_ff[AW-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = pidx_ff;
      ram_wr_data = ram_rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               key_in   = req_key;
               val_in   = req_value;
               cnt_in   = '0;
               found_in = 1'b0;
               have_in  = 1'b0;
               free_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff < CW'(DEPTH)) begin
               ram_rd_en = 1'b1;
               pend_in   = 1'b1;
               pidx_in   = cnt_ff[AW-1:0];
               cnt_in    = cnt_ff + CW'(1);
            end
            if (pend_ff) begin
               if (p_valid && !found_ff && (r_key == key_ff)) begin
                  found_in  = 1'b1;
                  mslot_in  = pidx_ff;
                  mdata_in  = r_data;
                  mcount_in = r_count;
                  mrank_in  = r_rank;
               end
               if (p_valid && (!have_ff || better)) begin
                  have_in   = 1'b1;
                  vslot_in  = pidx_ff;
                  vkey_in   = r_key;
                  vcount_in = r_count;
                  vrank_in  = r_rank;
               end
               if (!p_valid && !free_ff) begin
                  free_in  = 1'b1;
                  fslot_in = pidx_ff;
               end
            end
            if ((cnt_ff == CW'(DEPTH)) && !pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            hit_in    = found_ff;
            rdv_in    = '0;
            ev_in     = 1'b0;
            evk_in    = '0;
            mode_in   = AGE_NONE;
            slot_in   = mslot_ff;
            ref_in    = mrank_ff;
            nkey_in   = key_ff;
            ndata_in  = mdata_ff;
            ncount_in = mcount_inc;
            cnt_in    = '0;
            state_in  = ST_DONE;
            if (found_ff) begin
               if (op_ff == OP_GET) begin
                  rdv_in   = mdata_ff;
                  mode_in  = AGE_YOUNGER;
                  state_in = ST_UPDATE;
               end else if (!cap_zero) begin
                  ndata_in = val_ff;
                  mode_in  = AGE_YOUNGER;
                  state_in = ST_UPDATE;
               end
            end else if ((op_ff == OP_PUT) && !cap_zero) begin
               ndata_in  = val_ff;
               ncount_in = USE_W'(1);
               if (full && have_ff) begin
                  ev_in    = 1'b1;
                  evk_in   = vkey_ff;
                  slot_in  = vslot_ff;
                  ref_in   = vrank_ff;
                  mode_in  = AGE_YOUNGER;
                  state_in = ST_UPDATE;
               end else if (free_ff) begin
                  slot_in            = fslot_ff;
                  mode_in            = AGE_ALL;
                  valid_in[fslot_ff] = 1'b1;
                  fill_in            = fill_ff + CW'(1);
                  state_in           = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (cnt_ff < CW'(DEPTH)) begin
               ram_rd_en = 1'b1;
               pend_in   = 1'b1;
               pidx_in   = cnt_ff[AW-1:0];
               cnt_in    = cnt_ff + CW'(1);
            end
            if (pend_ff) begin
               if (pidx_ff == slot_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {nkey_ff, ndata_ff, ncount_ff, RW'(0)};
               end else if (p_valid && ((mode_ff == AGE_ALL) || (r_rank < ref_ff))) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {r_key, r_data, r_count, r_rank + RW'(1)};
               end
            end
            if ((cnt_ff == CW'(DEPTH)) && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         valid_ff <= '0;
         fill_ff  <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      cnt_ff    <= cnt_in;
      pidx_ff   <= pidx_in;
      found_ff  <= found_in;
      mslot_ff  <= mslot_in;
      mdata_ff  <= mdata_in;
      mcount_ff <= mcount_in;
      mrank_ff  <= mrank_in;
      have_ff   <= have_in;
      vslot_ff  <= vslot_in;
      vkey_ff   <= vkey_in;
      vcount_ff <= vcount_in;
      vrank_ff  <= vrank_in;
      free_ff   <= free_in;
      fslot_ff  <= fslot_in;
      slot_ff   <= slot_in;
      ref_ff    <= ref_in;
      mode_ff   <= mode_in;
      nkey_ff   <= nkey_in;
      ndata_ff  <= ndata_in;
      ncount_ff <= ncount_in;
      hit_ff    <= hit_in;
      rdv_ff    <= rdv_in;
      ev_ff     <= ev_in;
      evk_ff    <= evk_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = (state_ff == ST_DONE);
   assign rsp_hit         = hit_ff;
   assign rsp_read_value  = rdv_ff;
   assign rsp_evicted     = ev_ff;
   assign rsp_evicted_key = evk_ff;

endmodule

@@ hdl/lfu_ram.sv @@
// ----------------------------------------------------------------------------
// lfu_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// testbench for the lfu cache with lru tie-break: an in-bench predictor keeps
// its own copy of the entry table and the capacity register, predicts each
// response beat when a request is accepted, and the response checker compares
// every strobed beat field by field; directed corner cases come first, then
// random get/put traffic over small key pools at several capacity settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import lfu_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int LATENCY      = 2 * DEPTH + 6;
   localparam int LIMIT_CYCLES = 500000;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
      logic [KEY_W-1:0]  evicted_key;
   } cache_reply_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_opcode;
   logic signed [KEY_W-1:0]  req_key;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_strobe;
   logic                     rsp_hit;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic                     rsp_evicted;
   logic signed [KEY_W-1:0]  rsp_evicted_key;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_W-1:0]    paddr;
   logic [CSR_DATA_W-1:0]    pwdata;
   logic [CSR_DATA_W-1:0]    prdata;
   logic                     pready;

   // predictor state
   logic              slot_valid [DEPTH];
   logic [KEY_W-1:0]  slot_key   [DEPTH];
   logic [DATA_W-1:0] slot_data  [DEPTH];
   logic [USE_W-1:0]  slot_uses  [DEPTH];
   logic [3:0]        slot_age   [DEPTH];
   logic [CAP_W-1:0]  slot_fill;
   logic [CAP_W-1:0]  capacity_reg;

   cache_reply_type expected_replies [$];
   int              mismatch_count;
   bit              idle_on;

   lfu_cache_lru_tiebreak #(.DEPTH(DEPTH)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #6 clock = ~clock;

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("status: fail");
      $finish;
   end

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %h actual %h at %0t", what, want, got, $time);
   endtask

   always @(posedge clock) begin : reply_check
      cache_reply_type want;
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            note_mismatch("unexpected response beat", '0, '0);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_hit !== want.hit)
               note_mismatch("hit", want.hit, rsp_hit);
            if (rsp_read_value !== want.read_value)
               note_mismatch("read_value", want.read_value, rsp_read_value);
            if (rsp_evicted !== want.evicted)
               note_mismatch("evicted", want.evicted, rsp_evicted);
            if (rsp_evicted_key !== want.evicted_key)
               note_mismatch("evicted_key", want.evicted_key, rsp_evicted_key);
         end
      end
   end

   task automatic promote_slot(input int s);
      for (int i = 0; i < DEPTH; i++)
         if (slot_valid[i] && i != s && slot_age[i] < slot_age[s])
            slot_age[i]++;
      slot_age[s] = '0;
   endtask

   task automatic touch_slot(input int s);
      if (slot_uses[s] != '1)
         slot_uses[s]++;
      promote_slot(s);
   endtask

   task automatic predict_access(input logic op, input logic [KEY_W-1:0] key,
                                 input logic [DATA_W-1:0] value,
                                 output cache_reply_type reply);
      int cap_now;
      int slot;
      bit found;
      bit have;
      reply   = '0;
      cap_now = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
      found   = 0;
      slot    = 0;
      for (int i = 0; i < DEPTH; i++)
         if (!found && slot_valid[i] && slot_key[i] == key) begin
            slot  = i;
            found = 1;
         end
      reply.hit = found;
      if (op == OP_GET) begin
         if (found) begin
            reply.read_value = slot_data[slot];
            touch_slot(slot);
         end
      end else if (cap_now != 0) begin
         if (found) begin
            slot_data[slot] = value;
            touch_slot(slot);
         end else if (slot_fill >= cap_now) begin
            // least used entry, oldest one on a tie
            have = 0;
            for (int i = 0; i < DEPTH; i++)
               if (slot_valid[i] && (!have || slot_uses[i] < slot_uses[slot] ||
                   (slot_uses[i] == slot_uses[slot] && slot_age[i] > slot_age[slot]))) begin
                  slot = i;
                  have = 1;
               end
            reply.evicted     = 1'b1;
            reply.evicted_key = slot_key[slot];
            slot_key[slot]    = key;
            slot_data[slot]   = value;
            slot_uses[slot]   = 1;
            promote_slot(slot);
         end else begin
            have = 0;
            for (int i = 0; i < DEPTH; i++)
               if (!have && !slot_valid[i]) begin
                  slot = i;
                  have = 1;
               end
            slot_valid[slot] = 1'b1;
            slot_key[slot]   = key;
            slot_data[slot]  = value;
            slot_uses[slot]  = 1;
            for (int i = 0; i < DEPTH; i++)
               if (slot_valid[i] && i != slot)
                  slot_age[i]++;
            slot_age[slot] = '0;
            slot_fill++;
         end
      end
   endtask

   task automatic issue_access(input logic op, input logic [KEY_W-1:0] key,
                               input logic [DATA_W-1:0] value);
      cache_reply_type want;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1) == 1)
            while (busy) @(negedge clock);
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      start      = 1'b1;
      req_opcode = op;
      req_key    = key;
      req_value  = value;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_access(op, key, value, want);
      expected_replies.push_back(want);
      @(negedge clock);
      start      = 1'b0;
      req_opcode = 1'($urandom);
      req_key    = $urandom;
      req_value  = $urandom;
   endtask

   task automatic wait_drained();
      while (expected_replies.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic program_capacity(input int cap);
      logic [CSR_DATA_W-1:0] word;
      wait_drained();
      word             = $urandom;
      word[CAP_W-1:0]  = CAP_W'(cap);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_ADDR_W'(CSR_IDX_CAPACITY) << 2;
      pwdata  = word;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      capacity_reg = CAP_W'(cap);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      // read back
      psel = 1'b1;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== CSR_DATA_W'(capacity_reg))
         note_mismatch("capacity readback", CSR_DATA_W'(capacity_reg), prdata);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic test_directed_corners();
      issue_access(OP_GET, 32'h0000_0000, 32'h1234_5678);
      issue_access(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
      issue_access(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
      issue_access(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
      issue_access(OP_PUT, 32'h0000_0000, 32'h0000_0000);
      issue_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
      issue_access(OP_PUT, 32'hffff_ffff, 32'h5555_aaaa);
      issue_access(OP_GET, 32'hffff_ffff, 32'hffff_ffff);
      issue_access(OP_GET, 32'h0000_3039, 32'h0000_0000);
      // capacity below the fill: each new key replaces one victim
      program_capacity(2);
      issue_access(OP_PUT, 32'h0000_0001, 32'haaaa_5555);
      issue_access(OP_PUT, 32'h0000_0002, 32'h0f0f_0f0f);
      issue_access(OP_GET, 32'h0000_0002, 32'h0000_0000);
      issue_access(OP_PUT, 32'h0000_0003, 32'hf0f0_f0f0);
      // capacity zero: puts change nothing, gets still work
      program_capacity(0);
      issue_access(OP_PUT, 32'h0000_0002, 32'hdead_beef);
      issue_access(OP_PUT, 32'h0000_0063, 32'hdead_beef);
      issue_access(OP_GET, 32'h0000_0002, 32'h0000_0000);
      // capacity above depth
      program_capacity(31);
      issue_access(OP_PUT, 32'h0000_0004, 32'h0000_0004);
      issue_access(OP_PUT, 32'h8000_0001, 32'h8000_0001);
      issue_access(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
      issue_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
   endtask

   task automatic run_random_phase(input int cap, input int n_items, input bit pause_midway);
      logic [KEY_W-1:0] key_pool [24];
      int               pool_n;
      int               eff;
      logic [KEY_W-1:0] key;
      logic             op;
      program_capacity(cap);
      eff    = (cap > DEPTH) ? DEPTH : cap;
      pool_n = eff + $urandom_range(1, 6);
      for (int i = 0; i < pool_n; i++)
         key_pool[i] = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 31);
      for (int n = 0; n < n_items; n++) begin
         if (pause_midway && n == n_items / 2)
            wait_drained();
         if ($urandom_range(0, 15) == 0)
            key = $urandom;
         else
            key = key_pool[$urandom_range(0, pool_n - 1)];
         op = ($urandom_range(0, 9) < 5) ? OP_PUT : OP_GET;
         issue_access(op, key, $urandom);
      end
   endtask

   task automatic test_random_mix();
      int caps [12] = '{16, 1, 31, 0, 5, 17, 8, 2, 3, 16, 12, 31};
      for (int p = 0; p < 12; p++)
         run_random_phase(caps[p], 120, p == 4);
      run_random_phase($urandom_range(0, 31), 60, 1'b0);
   endtask

   task automatic test_unthrottled_tail();
      idle_on = 1'b0;
      run_random_phase($urandom_range(4, 16), 150, 1'b0);
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_GET;
      req_key        = '0;
      req_value      = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      mismatch_count = 0;
      idle_on        = 1'b1;
      slot_fill      = '0;
      capacity_reg   = CAP_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_data[i]  = '0;
         slot_uses[i]  = '0;
         slot_age[i]   = '0;
      end
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_directed_corners();
      test_random_mix();
      test_unthrottled_tail();
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
